// File: hw/rtl/mh64b_pkg.sv
// Shared types, constants and mixing helpers for the murmur64b_hash block.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mh64b_pkg;

  localparam logic [31:0] MixMul     = 32'h5bd1e995;
  localparam int unsigned MixShift   = 24;
  localparam logic [31:0] SeedReset  = 32'd97;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_PART
  } kind_e;

  // One classified word handed from the front to the back.
  typedef struct packed {
    kind_e       kind;
    logic        first;
    logic        last;
    logic [31:0] data;   // scrambled full word, or masked tail bytes
    logic [31:0] init;   // seed xor length, used when first is set
  } op_t;

  // Low 32 bits of x times the mixing constant.
  function automatic logic [31:0] mul_mix(input logic [31:0] x);
    logic [31:0] p;
    p = x * MixMul;
    return p;
  endfunction

  // Shift amount of each of the four final cross-mix rounds.
  function automatic logic [4:0] fin_shift(input logic [1:0] round);
    logic [4:0] s;
    unique case (round)
      2'd0: s = 5'd18;
      2'd1: s = 5'd22;
      2'd2: s = 5'd17;
      2'd3: s = 5'd19;
      default: s = 5'd18;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mh64b_front.sv
// Front end of murmur64b_hash: accepts words, classifies them, scrambles full words.
// Depends on mh64b_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh64b_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               seed_we_i,
  input  wire logic [31:0]        seed_i,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [31:0]        data_word_i,
  input  wire logic [2:0]         valid_bytes_i,
  input  wire logic               last_i,
  input  wire logic [31:0]        total_length_i,
  output logic                    op_valid_o,
  input  wire logic               op_full_i,
  output mh64b_pkg::op_t          op_o
);

  logic [31:0]    seed_val_q;
  logic           in_msg_q;
  logic           s1_valid_q;
  mh64b_pkg::op_t s1_q;
  mh64b_pkg::op_t s1_d;
  logic           accept;
  logic           advance;
  logic [31:0]    tail;
  logic [31:0]    mixed;

  assign advance = s1_valid_q & ~op_full_i;
  assign full_o  = s1_valid_q & op_full_i;
  assign accept  = push_i & ~full_o;

  always_comb begin
    unique case (valid_bytes_i)
      3'd1:    tail = {24'd0, data_word_i[7:0]};
      3'd2:    tail = {16'd0, data_word_i[15:0]};
      3'd3:    tail = {8'd0, data_word_i[23:0]};
      default: tail = '0;
    endcase
  end

  // First multiply of the scramble happens here, the second on the way out.
  always_comb begin
    s1_d.first = ~in_msg_q;
    s1_d.last  = last_i;
    s1_d.init  = seed_val_q ^ total_length_i;
    if (valid_bytes_i >= 3'd4) begin
      s1_d.kind = mh64b_pkg::KIND_FULL;
      s1_d.data = mh64b_pkg::mul_mix(data_word_i);
    end else if (valid_bytes_i == 3'd0) begin
      s1_d.kind = mh64b_pkg::KIND_NONE;
      s1_d.data = '0;
    end else begin
      s1_d.kind = mh64b_pkg::KIND_PART;
      s1_d.data = tail;
    end
  end

  assign mixed = s1_q.data ^ (s1_q.data >> mh64b_pkg::MixShift);

  always_comb begin
    op_o = s1_q;
    if (s1_q.kind == mh64b_pkg::KIND_FULL) begin
      op_o.data = mh64b_pkg::mul_mix(mixed);
    end
  end

  assign op_valid_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_val_q <= mh64b_pkg::SeedReset;
      in_msg_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (seed_we_i) begin
        seed_val_q <= seed_i;
      end
      if (accept) begin
        in_msg_q   <= ~last_i;
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mh64b_fifo.sv
// Short show-ahead queue of classified words between the front and back ends.
// Depends on mh64b_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh64b_fifo #(
  parameter int unsigned Depth = mh64b_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire mh64b_pkg::op_t wr_data_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output mh64b_pkg::op_t      rd_data_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mh64b_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr;
  logic            do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(Depth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mh64b_back.sv
// Back end of murmur64b_hash: accumulator updates, final cross-mix, result register.
// Depends on mh64b_pkg; shares one constant multiplier over all steps.
`timescale 1ns / 1ps
`default_nettype none

module mh64b_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mh64b_pkg::op_t op_i,
  input  wire logic           op_empty_i,
  output logic                op_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic [63:0]         hash_value_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_FIN
  } state_e;

  state_e         state_q;
  mh64b_pkg::op_t ent_q;
  logic [31:0]    acc1_q;
  logic [31:0]    acc2_q;
  logic           parity_q;
  logic [1:0]     round_q;
  logic           out_valid_q;
  logic           out_valid_d;
  logic [63:0]    hash_q;
  logic [31:0]    mul_in;
  logic [31:0]    mul_out;
  logic [4:0]     shamt;
  logic           out_pop;
  logic           out_free;
  logic           fin_done;

  assign out_pop      = pop_i & out_valid_q;
  assign out_free     = ~out_valid_q | out_pop;
  assign fin_done     = (state_q == ST_FIN) & (round_q == 2'd3) & out_free;
  assign out_valid_d  = fin_done | (out_valid_q & ~out_pop);
  assign empty_o      = ~out_valid_q;
  assign hash_value_o = hash_q;
  assign op_pop_o     = (state_q == ST_IDLE) & ~op_empty_i;
  assign shamt        = mh64b_pkg::fin_shift(round_q);

  always_comb begin
    unique case (state_q)
      ST_DATA: begin
        if (ent_q.kind == mh64b_pkg::KIND_FULL) begin
          mul_in = parity_q ? acc2_q : acc1_q;
        end else begin
          mul_in = acc2_q ^ ent_q.data;
        end
      end
      ST_FIN: begin
        mul_in = round_q[0] ? (acc2_q ^ (acc1_q >> shamt)) : (acc1_q ^ (acc2_q >> shamt));
      end
      default: mul_in = acc1_q;
    endcase
  end

  assign mul_out = mh64b_pkg::mul_mix(mul_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      parity_q    <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (!op_empty_i) begin
            if (op_i.first) begin
              parity_q <= 1'b0;
            end
            if (op_i.kind != mh64b_pkg::KIND_NONE) begin
              state_q <= ST_DATA;
            end else if (op_i.last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_DATA: begin
          if (ent_q.kind == mh64b_pkg::KIND_FULL) begin
            parity_q <= ~parity_q;
          end
          state_q <= ent_q.last ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (round_q != 2'd3) begin
            round_q <= round_q + 2'd1;
          end else if (out_free) begin
            round_q     <= '0;
            parity_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: accumulators, held word and result.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!op_empty_i) begin
          ent_q <= op_i;
          if (op_i.first) begin
            acc1_q <= op_i.init;
            acc2_q <= '0;
          end
        end
      end
      ST_DATA: begin
        if (ent_q.kind == mh64b_pkg::KIND_FULL) begin
          if (parity_q) begin
            acc2_q <= mul_out ^ ent_q.data;
          end else begin
            acc1_q <= mul_out ^ ent_q.data;
          end
        end else if (ent_q.kind == mh64b_pkg::KIND_PART) begin
          acc2_q <= mul_out;
        end
      end
      ST_FIN: begin
        if (round_q != 2'd3) begin
          if (round_q[0]) begin
            acc2_q <= mul_out;
          end else begin
            acc1_q <= mul_out;
          end
        end else if (out_free) begin
          acc2_q <= mul_out;
          hash_q <= {acc1_q, mul_out};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/murmur64b_hash.sv
// Top level of the streaming MurmurHash64B engine.
// Depends on mh64b_pkg, mh64b_front, mh64b_fifo and mh64b_back.
// Usage:
//   Input channel: present a word on data_word_i/valid_bytes_i/last_i/total_length_i
//   and raise push; the word is taken at an edge where push is high and full is
//   low. total_length_i counts only on the first word of a message. Words below
//   four valid bytes belong at the end of a message.
//   Result channel: while empty is low, hash_value_o holds the oldest hash; raise
//   pop to take it. One hash per message, on the word with last_i set.
//   Seed: pulse seed_we_i with seed_i while the block is idle; it applies from
//   the next message.
// Timing:
//   The front end registers a word and hands it to a four-word queue. The back
//   end fetches each word from the queue in ST_IDLE and does one accumulator
//   multiply in ST_DATA on its shared multiplier; after the last word it runs
//   the final cross-mix rounds in ST_FIN. It takes a new word only in ST_IDLE,
//   so it cannot start a word before it is through with the previous one; the
//   back end sets the sustained rate.
// Reset empties the queue and result register and restores the seed to 97. When
// the receiver stalls, the back end holds its last round, the queue fills, and
// full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module murmur64b_hash #(
  parameter int unsigned QueueDepth = mh64b_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_i,
  input  wire logic [31:0] total_length_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      hash_value_o
);

  mh64b_pkg::op_t fr_op;
  mh64b_pkg::op_t bk_op;
  logic           fr_valid;
  logic           q_full;
  logic           q_empty;
  logic           bk_pop;

  // Take words, classify them, scramble full words.
  mh64b_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_we_i      (seed_we_i),
    .seed_i         (seed_i),
    .push_i         (push),
    .full_o         (full),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_i         (last_i),
    .total_length_i (total_length_i),
    .op_valid_o     (fr_valid),
    .op_full_i      (q_full),
    .op_o           (fr_op)
  );

  // Decouple the front end from the back end.
  mh64b_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_valid),
    .wr_data_i (fr_op),
    .full_o    (q_full),
    .rd_i      (bk_pop),
    .rd_data_o (bk_op),
    .empty_o   (q_empty)
  );

  // Fold words into the accumulators and finish each message.
  mh64b_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (bk_op),
    .op_empty_i   (q_empty),
    .op_pop_o     (bk_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .hash_value_o (hash_value_o)
  );

endmodule

`default_nettype wire
